// ----- design/mpzg_pkg.sv -----
// Shared types and constants for the matrix peak zone grow block.
// Used by every module of the block; no dependencies of its own.
package mpzg_pkg;

  // Geometry and sample format
  localparam int MAX_DIM     = 64;
  localparam int SAMPLE_BITS = 16;
  localparam int COORD_W     = $clog2(MAX_DIM);
  localparam int DIM_W       = COORD_W + 1;
  localparam int ADDR_W      = 2 * COORD_W;
  localparam int DEPTH       = 1 << ADDR_W;
  localparam int CW          = COORD_W + 3;    // signed ring coordinate
  localparam int CNT_W       = ADDR_W + 1;

  // Accumulators and divider
  localparam int WS_W       = 32;
  localparam int MOM_W      = 40;
  localparam int NUM_W      = MOM_W + 8;
  localparam int DEN_W      = SAMPLE_BITS + ADDR_W;
  localparam int Q_W        = DEN_W;
  localparam int KW         = $clog2(Q_W);
  localparam int CENT_BITS  = 14;

  // Stream widths
  localparam int IN_W  = ((ADDR_W + SAMPLE_BITS + 2 + 7) / 8) * 8;
  localparam int OUT_W = 96;

  localparam logic signed [CW-1:0] C_ONE  = CW'(1);
  localparam logic signed [CW-1:0] C_ZERO = '0;

  // Actions carried in tuser
  localparam logic [1:0] ACT_LOAD   = 2'd0;
  localparam logic [1:0] ACT_FIND   = 2'd1;
  localparam logic [1:0] ACT_READ   = 2'd2;
  localparam logic [1:0] ACT_RETIRE = 2'd3;

  // Cell marks
  localparam logic [1:0] MARK_FREE = 2'd0;
  localparam logic [1:0] MARK_ZONE = 2'd1;
  localparam logic [1:0] MARK_EXCL = 2'd2;

  // Register indexes
  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;
  localparam logic [1:0] REG_THRESH = 2'd2;

  // Store access for one cycle
  typedef struct packed {
    logic [ADDR_W-1:0]             rd_addr;
    logic                          mk_we;
    logic [ADDR_W-1:0]             mk_addr;
    logic [1:0]                    mk_data;
    logic                          sm_we;
    logic [ADDR_W-1:0]             sm_addr;
    logic signed [SAMPLE_BITS-1:0] sm_data;
  } store_req_t;

  // Divider launch
  typedef struct packed {
    logic             start;
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
    logic [KW-1:0]    top;
  } div_req_t;

  // Result item, last field in the lowest bits
  typedef struct packed {
    logic [1:0]                    cell_mark;
    logic signed [SAMPLE_BITS-1:0] peak_value;
    logic signed [SAMPLE_BITS-1:0] zone_mean;
    logic                          centroid_bad;
    logic [CENT_BITS-1:0]          centroid_row;
    logic [CENT_BITS-1:0]          centroid_col;
    logic [COORD_W-1:0]            peak_row;
    logic [COORD_W-1:0]            peak_col;
    logic [CNT_W-1:0]              zone_count;
    logic                          found;
  } result_t;

endpackage

// ----- design/mpzg_store.sv -----
// Sample and mark memories, one write port each and a shared registered read.
// Depends on mpzg_pkg.
module mpzg_store (
  input  logic                                    clk_i,
  input  mpzg_pkg::store_req_t                    req_i,
  output logic signed [mpzg_pkg::SAMPLE_BITS-1:0] rd_sample_o,
  output logic [1:0]                              rd_mark_o
);
  import mpzg_pkg::*;

  logic signed [SAMPLE_BITS-1:0] sample_mem [DEPTH];
  logic [1:0]                    mark_mem   [DEPTH];

  // Sample memory
  always_ff @(posedge clk_i) begin
    if (req_i.sm_we) begin
      sample_mem[req_i.sm_addr] <= req_i.sm_data;
    end
    rd_sample_o <= sample_mem[req_i.rd_addr];
  end

  // Mark memory
  always_ff @(posedge clk_i) begin
    if (req_i.mk_we) begin
      mark_mem[req_i.mk_addr] <= req_i.mk_data;
    end
    rd_mark_o <= mark_mem[req_i.rd_addr];
  end

endmodule

// ----- design/mpzg_div.sv -----
// Shared restoring divider, one quotient bit per cycle from a chosen top bit.
// Depends on mpzg_pkg.
module mpzg_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  mpzg_pkg::div_req_t         req_i,
  output logic                       busy_o,
  output logic                       done_o,
  output logic [mpzg_pkg::Q_W-1:0]   quot_o
);
  import mpzg_pkg::*;

  localparam int TR_W = DEN_W + Q_W;

  logic [NUM_W-1:0] rem_q;
  logic [DEN_W-1:0] den_q;
  logic [KW-1:0]    k_q;
  logic [Q_W-1:0]   q_q;
  logic             busy_q, done_q;
  logic [TR_W-1:0]  trial;

  // Shifted divisor for the current bit
  assign trial = TR_W'(den_q) << k_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      rem_q  <= '0;
      den_q  <= '0;
      k_q    <= '0;
      q_q    <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        rem_q  <= req_i.num;
        den_q  <= req_i.den;
        k_q    <= req_i.top;
        q_q    <= '0;
        busy_q <= 1'b1;
      end else if (busy_q) begin
        if (trial <= TR_W'(rem_q)) begin
          rem_q    <= rem_q - trial[NUM_W-1:0];
          q_q[k_q] <= 1'b1;
        end
        if (k_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          k_q <= k_q - KW'(1);
        end
      end
    end
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign quot_o = q_q;

endmodule

// ----- design/matrix_peak_zone_grow_top.sv -----
// Top level of the matrix peak zone grow block: sequencer, ring walker, sums.
// Depends on mpzg_pkg, mpzg_store and mpzg_div.
//
// Usage: samples are loaded over the slave stream (tuser = action, tdata =
// cell_index, sample_value, sample_valid, sample_excluded). A load keeps the
// block idle, so the next transaction is taken in the following cycle. A read
// uses ST_RDW and ST_FIN and returns one result with cell_mark set. A find runs:
//   - a sweep of all 4096 marks that frees old zone marks and picks the seed
//     and, if none is found, goes straight to the result,
//   - the ring growth, each ring cell through SUB_CELL, SUB_A, SUB_B and SUB_DEC
//     on the single store read port, a skipped ring side through SUB_CELL only,
//   - a sweep over the store for the sums,
//   - up to three divisions on one shared divider,
// then emits one result. A retire sweeps all marks and gives no result. While a
// command runs, s_axis_tready is low. Results sit in an output register; if the
// receiver stalls, the next finished command waits in ST_FIN and the slave side
// stays closed until the register is free.
// Reset clears the control state and sets width 64, height 64, threshold 0;
// the memories are not cleared. Configuration is always ready.
module matrix_peak_zone_grow_top
  import mpzg_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  // Configuration write channel
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [1:0]        cfg_addr_i,
  input  logic [15:0]       cfg_data_i,
  // Command stream
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  // [11:0] cell_index, [27:12] sample_value, [28] sample_valid,
  // [29] sample_excluded, [31:30] zero
  input  logic [IN_W-1:0]   s_axis_tdata,
  // [1:0] action
  input  logic [1:0]        s_axis_tuser,
  // Result stream
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  // [0] found, [13:1] zone_count, [19:14] peak_col, [25:20] peak_row,
  // [39:26] centroid_col, [53:40] centroid_row, [54] centroid_bad,
  // [70:55] zone_mean, [86:71] peak_value, [88:87] cell_mark, [95:89] zero
  output logic [OUT_W-1:0]  m_axis_tdata
);

  typedef enum logic [8:0] {
    ST_IDLE = 9'b000000001,
    ST_RDW  = 9'b000000010,
    ST_CLR  = 9'b000000100,
    ST_SEED = 9'b000001000,
    ST_GROW = 9'b000010000,
    ST_SUM  = 9'b000100000,
    ST_DIV  = 9'b001000000,
    ST_FIN  = 9'b010000000,
    ST_RET  = 9'b100000000
  } state_e;

  localparam logic [2:0] SEG_TOP = 3'd0;
  localparam logic [2:0] SEG_BOT = 3'd1;
  localparam logic [2:0] SEG_LFT = 3'd2;
  localparam logic [2:0] SEG_RGT = 3'd3;
  localparam logic [2:0] SEG_TL  = 3'd4;
  localparam logic [2:0] SEG_TR  = 3'd5;
  localparam logic [2:0] SEG_BL  = 3'd6;
  localparam logic [2:0] SEG_BR  = 3'd7;

  localparam logic [1:0] SUB_CELL = 2'd0;
  localparam logic [1:0] SUB_A    = 2'd1;
  localparam logic [1:0] SUB_B    = 2'd2;
  localparam logic [1:0] SUB_DEC  = 2'd3;

  localparam logic [1:0] DIV_CCOL = 2'd0;
  localparam logic [1:0] DIV_CROW = 2'd1;
  localparam logic [1:0] DIV_MEAN = 2'd2;

  localparam int RES_W = $bits(result_t);

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
    logic [DIM_W-1:0] r;
    r = v;
    if (v == '0) r = DIM_W'(1);
    if (v > DIM_W'(MAX_DIM)) r = DIM_W'(MAX_DIM);
    return r;
  endfunction

  function automatic logic in_mat(input logic signed [CW-1:0] x, y, w, h);
    return (x >= C_ZERO) && (y >= C_ZERO) && (x < w) && (y < h);
  endfunction

  // Registers
  state_e                        state_q, state_d;
  logic [DIM_W-1:0]              w_q, w_d, h_q, h_d;
  logic signed [SAMPLE_BITS-1:0] thr_q, thr_d;
  logic [ADDR_W:0]               sw_i_q, sw_i_d, sw_y_q, sw_y_d;
  logic [DIM_W-1:0]              sw_x_q, sw_x_d;
  logic                          s1_v_q, s1_v_d;
  logic [ADDR_W-1:0]             s1_i_q, s1_i_d;
  logic [DIM_W-1:0]              s1_x_q, s1_x_d;
  logic [ADDR_W:0]               s1_y_q, s1_y_d;
  logic                          s2_v_q, s2_v_d;
  logic signed [MOM_W-1:0]       mx_q, mx_d, my_q, my_d;
  logic signed [SAMPLE_BITS-1:0] s2_s_q, s2_s_d;
  logic signed [WS_W-1:0]        ws_q, ws_d;
  logic signed [MOM_W-1:0]       cm_q, cm_d, rm_q, rm_d;
  logic [CNT_W-1:0]              cnt_q, cnt_d;
  logic signed [SAMPLE_BITS-1:0] best_q, best_d;
  logic                          seed_ok_q, seed_ok_d;
  logic [ADDR_W-1:0]             seed_idx_q, seed_idx_d;
  logic [COORD_W-1:0]            seed_x_q, seed_x_d, seed_y_q, seed_y_d;
  logic [DIM_W-1:0]              r_q, r_d, t_q, t_d;
  logic [2:0]                    seg_q, seg_d;
  logic [1:0]                    sub_q, sub_d;
  logic                          grew_q, grew_d;
  logic signed [SAMPLE_BITS-1:0] cell_s_q, cell_s_d;
  logic [1:0]                    cell_m_q, cell_m_d;
  logic                          a_z_q, a_z_d;
  logic [1:0]                    dsel_q, dsel_d;
  logic                          dwait_q, dwait_d;
  logic                          out_v_q, out_v_d;
  result_t                       res_q, res_d, out_q, out_d;

  // Store and divider
  store_req_t                    sreq;
  div_req_t                      dreq;
  logic signed [SAMPLE_BITS-1:0] rd_sample;
  logic [1:0]                    rd_mark;
  logic                          div_busy, div_done;
  logic [Q_W-1:0]                div_q;

  mpzg_store u_store (
    .clk_i       (clk_i),
    .req_i       (sreq),
    .rd_sample_o (rd_sample),
    .rd_mark_o   (rd_mark)
  );

  mpzg_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (dreq),
    .busy_o (div_busy),
    .done_o (div_done),
    .quot_o (div_q)
  );

  // Input fields
  logic                          in_fire;
  logic [ADDR_W-1:0]             in_idx;
  logic signed [SAMPLE_BITS-1:0] in_val;
  logic                          in_sv, in_sx;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign in_idx        = s_axis_tdata[ADDR_W-1:0];
  assign in_val        = s_axis_tdata[ADDR_W +: SAMPLE_BITS];
  assign in_sv         = s_axis_tdata[ADDR_W+SAMPLE_BITS];
  assign in_sx         = s_axis_tdata[ADDR_W+SAMPLE_BITS+1];
  assign cfg_ready_o   = 1'b1;

  // Ring geometry around the seed
  logic [DIM_W-1:0]        range_dim;
  logic signed [CW-1:0]    px, py, rr, ww, hh, tt;
  logic signed [CW-1:0]    top_y, bot_y, lft_x, rgt_x, xa, xb, ya, yb, xa0, xb0, ya0, yb0;
  logic signed [CW-1:0]    cx, cy, ax, ay, bx, by, mul_x, mul_y;
  logic [7:0]              seg_en_v;
  logic                    seg_en, seg_last, a_in, b_in, cell_in;
  logic [COORD_W+DIM_W-1:0] prod;
  logic [ADDR_W-1:0]       grow_addr;

  assign range_dim = (w_q > h_q) ? w_q : h_q;
  assign px    = $signed({3'b000, seed_x_q});
  assign py    = $signed({3'b000, seed_y_q});
  assign rr    = $signed({2'b00, r_q});
  assign ww    = $signed({2'b00, w_q});
  assign hh    = $signed({2'b00, h_q});
  assign tt    = $signed({2'b00, t_q});
  assign top_y = py - rr;
  assign bot_y = py + rr;
  assign lft_x = px - rr;
  assign rgt_x = px + rr;
  assign xa0   = lft_x + C_ONE;
  assign xb0   = rgt_x - C_ONE;
  assign ya0   = top_y + C_ONE;
  assign yb0   = bot_y - C_ONE;
  assign xa    = (xa0 < C_ZERO) ? C_ZERO : xa0;
  assign xb    = (xb0 > ww - C_ONE) ? ww - C_ONE : xb0;
  assign ya    = (ya0 < C_ZERO) ? C_ZERO : ya0;
  assign yb    = (yb0 > hh - C_ONE) ? hh - C_ONE : yb0;

  assign seg_en_v[SEG_TOP] = (top_y >= C_ZERO);
  assign seg_en_v[SEG_BOT] = (bot_y < hh);
  assign seg_en_v[SEG_LFT] = (lft_x >= C_ZERO);
  assign seg_en_v[SEG_RGT] = (rgt_x < ww);
  assign seg_en_v[SEG_TL]  = seg_en_v[SEG_TOP] && seg_en_v[SEG_LFT];
  assign seg_en_v[SEG_TR]  = seg_en_v[SEG_TOP] && seg_en_v[SEG_RGT];
  assign seg_en_v[SEG_BL]  = seg_en_v[SEG_BOT] && seg_en_v[SEG_LFT];
  assign seg_en_v[SEG_BR]  = seg_en_v[SEG_BOT] && seg_en_v[SEG_RGT];
  assign seg_en            = seg_en_v[seg_q];

  // Current ring cell and the two neighbours it checks
  always_comb begin
    cx = xa + tt;
    cy = top_y;
    ax = cx - C_ONE;
    ay = cy;
    bx = cx;
    by = cy + C_ONE;
    seg_last = 1'b1;
    case (seg_q)
      SEG_TOP: begin
        cx = xa + tt; cy = top_y;
        ax = cx - C_ONE; ay = cy; bx = cx; by = cy + C_ONE;
        seg_last = (cx == xb);
      end
      SEG_BOT: begin
        cx = xa + tt; cy = bot_y;
        ax = cx - C_ONE; ay = cy; bx = cx; by = cy - C_ONE;
        seg_last = (cx == xb);
      end
      SEG_LFT: begin
        cx = lft_x; cy = ya + tt;
        ax = cx; ay = cy - C_ONE; bx = cx + C_ONE; by = cy;
        seg_last = (cy == yb);
      end
      SEG_RGT: begin
        cx = rgt_x; cy = ya + tt;
        ax = cx; ay = cy - C_ONE; bx = cx - C_ONE; by = cy;
        seg_last = (cy == yb);
      end
      SEG_TL: begin
        cx = lft_x; cy = top_y;
        ax = cx; ay = cy + C_ONE; bx = cx + C_ONE; by = cy;
      end
      SEG_TR: begin
        cx = rgt_x; cy = top_y;
        ax = cx; ay = cy + C_ONE; bx = cx - C_ONE; by = cy;
      end
      SEG_BL: begin
        cx = lft_x; cy = bot_y;
        ax = cx; ay = cy - C_ONE; bx = cx + C_ONE; by = cy;
      end
      default: begin
        cx = rgt_x; cy = bot_y;
        ax = cx; ay = cy - C_ONE; bx = cx - C_ONE; by = cy;
      end
    endcase
  end

  assign a_in    = in_mat(ax, ay, ww, hh);
  assign b_in    = in_mat(bx, by, ww, hh);
  assign cell_in = in_mat(cx, cy, ww, hh);

  // Shared address multiplier: row times width plus column
  always_comb begin
    case (sub_q)
      SUB_A:   begin mul_x = ax; mul_y = ay; end
      SUB_B:   begin mul_x = bx; mul_y = by; end
      default: begin mul_x = cx; mul_y = cy; end
    endcase
  end

  assign prod      = mul_y[COORD_W-1:0] * w_q;
  assign grow_addr = prod[ADDR_W-1:0] + ADDR_W'(mul_x[COORD_W-1:0]);

  // Sweep helpers
  logic                    sweep_run, sweep_end, s1_in, start_sweep;
  logic                    adv, last_eff, add, grew_any;
  logic signed [MOM_W-1:0] mom_sel;
  logic [WS_W-1:0]         ws_abs;
  logic [Q_W-1:0]          q_neg;

  assign sweep_run = state_q inside {ST_CLR, ST_SUM, ST_RET};
  assign sweep_end = sw_i_q[ADDR_W] && !s1_v_q && !s2_v_q;
  assign s1_in     = s1_v_q && (s1_y_q < (ADDR_W+1)'(h_q));
  assign mom_sel   = (dsel_q == DIV_CCOL) ? cm_q : rm_q;
  assign ws_abs    = ws_q[WS_W-1] ? WS_W'(-ws_q) : WS_W'(ws_q);
  assign q_neg     = ~div_q + Q_W'(1);

  // Sequencer
  always_comb begin
    state_d    = state_q;
    w_d        = w_q;
    h_d        = h_q;
    thr_d      = thr_q;
    sw_i_d     = sw_i_q;
    sw_x_d     = sw_x_q;
    sw_y_d     = sw_y_q;
    s1_v_d     = 1'b0;
    s1_i_d     = s1_i_q;
    s1_x_d     = s1_x_q;
    s1_y_d     = s1_y_q;
    s2_v_d     = 1'b0;
    mx_d       = mx_q;
    my_d       = my_q;
    s2_s_d     = s2_s_q;
    ws_d       = ws_q;
    cm_d       = cm_q;
    rm_d       = rm_q;
    cnt_d      = cnt_q;
    best_d     = best_q;
    seed_ok_d  = seed_ok_q;
    seed_idx_d = seed_idx_q;
    seed_x_d   = seed_x_q;
    seed_y_d   = seed_y_q;
    r_d        = r_q;
    t_d        = t_q;
    seg_d      = seg_q;
    sub_d      = sub_q;
    grew_d     = grew_q;
    cell_s_d   = cell_s_q;
    cell_m_d   = cell_m_q;
    a_z_d      = a_z_q;
    dsel_d     = dsel_q;
    dwait_d    = dwait_q;
    res_d      = res_q;
    out_d      = out_q;
    out_v_d    = out_v_q && !m_axis_tready;
    sreq         = '0;
    sreq.rd_addr = sw_i_q[ADDR_W-1:0];
    dreq       = '0;
    start_sweep = 1'b0;
    adv        = 1'b0;
    last_eff   = 1'b0;
    add        = 1'b0;
    grew_any   = grew_q;

    // Configuration writes
    if (cfg_valid_i) begin
      case (cfg_addr_i)
        REG_WIDTH:  w_d   = clamp_dim(cfg_data_i[DIM_W-1:0]);
        REG_HEIGHT: h_d   = clamp_dim(cfg_data_i[DIM_W-1:0]);
        REG_THRESH: thr_d = $signed(cfg_data_i);
        default: ;
      endcase
    end

    // Linear sweep over the store with one read stage
    if (sweep_run) begin
      s1_v_d = !sw_i_q[ADDR_W];
      s1_i_d = sw_i_q[ADDR_W-1:0];
      s1_x_d = sw_x_q;
      s1_y_d = sw_y_q;
      if (!sw_i_q[ADDR_W]) begin
        sw_i_d = sw_i_q + (ADDR_W+1)'(1);
        if (sw_x_q == w_q - DIM_W'(1)) begin
          sw_x_d = '0;
          sw_y_d = sw_y_q + (ADDR_W+1)'(1);
        end else begin
          sw_x_d = sw_x_q + DIM_W'(1);
        end
      end
    end

    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          case (s_axis_tuser)
            ACT_LOAD: begin
              sreq.sm_we   = 1'b1;
              sreq.sm_addr = in_idx;
              sreq.sm_data = in_val;
              sreq.mk_we   = 1'b1;
              sreq.mk_addr = in_idx;
              sreq.mk_data = (!in_sv || in_sx) ? MARK_EXCL : MARK_FREE;
            end
            ACT_FIND: begin
              res_d       = '0;
              best_d      = thr_q;
              seed_ok_d   = 1'b0;
              start_sweep = 1'b1;
              state_d     = ST_CLR;
            end
            ACT_READ: begin
              sreq.rd_addr = in_idx;
              res_d        = '0;
              state_d      = ST_RDW;
            end
            default: begin
              start_sweep = 1'b1;
              state_d     = ST_RET;
            end
          endcase
        end
      end

      ST_RDW: begin
        res_d.cell_mark = rd_mark;
        state_d         = ST_FIN;
      end

      // Free stale zone marks and pick the seed
      ST_CLR: begin
        if (s1_v_q) begin
          if (rd_mark == MARK_ZONE) begin
            sreq.mk_we   = 1'b1;
            sreq.mk_addr = s1_i_q;
            sreq.mk_data = MARK_FREE;
          end
          if (s1_in && rd_mark != MARK_EXCL && rd_sample > best_q) begin
            best_d     = rd_sample;
            seed_ok_d  = 1'b1;
            seed_idx_d = s1_i_q;
            seed_x_d   = s1_x_q[COORD_W-1:0];
            seed_y_d   = s1_y_q[COORD_W-1:0];
          end
        end
        if (sweep_end) begin
          state_d = seed_ok_q ? ST_SEED : ST_FIN;
        end
      end

      ST_SEED: begin
        sreq.mk_we       = 1'b1;
        sreq.mk_addr     = seed_idx_q;
        sreq.mk_data     = MARK_ZONE;
        res_d.found      = 1'b1;
        res_d.peak_col   = seed_x_q;
        res_d.peak_row   = seed_y_q;
        res_d.peak_value = best_q;
        r_d    = DIM_W'(1);
        seg_d  = SEG_TOP;
        t_d    = '0;
        sub_d  = SUB_CELL;
        grew_d = 1'b0;
        if (range_dim > DIM_W'(1)) begin
          state_d = ST_GROW;
        end else begin
          start_sweep = 1'b1;
          state_d     = ST_SUM;
        end
      end

      // Each ring cell steps through SUB_CELL, SUB_A, SUB_B and SUB_DEC on the shared read port
      ST_GROW: begin
        sreq.rd_addr = grow_addr;
        case (sub_q)
          SUB_CELL: begin
            if (!seg_en) begin
              adv      = 1'b1;
              last_eff = 1'b1;
            end else begin
              sub_d = SUB_A;
            end
          end
          SUB_A: begin
            cell_s_d = rd_sample;
            cell_m_d = rd_mark;
            sub_d    = SUB_B;
          end
          SUB_B: begin
            a_z_d = a_in && (rd_mark == MARK_ZONE);
            sub_d = SUB_DEC;
          end
          default: begin
            add = (cell_s_q >= thr_q) && (cell_m_q == MARK_FREE) &&
                  (a_z_q || (b_in && rd_mark == MARK_ZONE));
            if (add) begin
              sreq.mk_we   = 1'b1;
              sreq.mk_addr = grow_addr;
              sreq.mk_data = MARK_ZONE;
            end
            adv      = 1'b1;
            last_eff = seg_last;
          end
        endcase
        if (adv) begin
          sub_d    = SUB_CELL;
          grew_any = grew_q || add;
          if (last_eff) begin
            t_d = '0;
            if (seg_q == SEG_BR) begin
              if (!grew_any || r_q == range_dim - DIM_W'(1)) begin
                start_sweep = 1'b1;
                state_d     = ST_SUM;
              end else begin
                r_d    = r_q + DIM_W'(1);
                seg_d  = SEG_TOP;
                grew_d = 1'b0;
              end
            end else begin
              seg_d  = seg_q + 3'd1;
              grew_d = grew_any;
            end
          end else begin
            t_d    = t_q + DIM_W'(1);
            grew_d = grew_any;
          end
        end
      end

      // Weight and moment sums: multiply stage, then accumulate
      ST_SUM: begin
        s2_v_d = s1_in && (rd_mark == MARK_ZONE);
        s2_s_d = rd_sample;
        mx_d   = $signed({1'b0, s1_x_q}) * rd_sample;
        my_d   = $signed({1'b0, s1_y_q[COORD_W-1:0]}) * rd_sample;
        if (s2_v_q) begin
          ws_d  = ws_q + WS_W'(s2_s_q);
          cm_d  = cm_q + mx_q;
          rm_d  = rm_q + my_q;
          cnt_d = cnt_q + CNT_W'(1);
        end
        if (sweep_end) begin
          res_d.zone_count   = cnt_q;
          res_d.centroid_bad = (ws_q <= 0);
          dsel_d  = DIV_CCOL;
          dwait_d = 1'b0;
          state_d = ST_DIV;
        end
      end

      // Centroids and mean on the shared divider
      ST_DIV: begin
        if (!dwait_q) begin
          if (dsel_q == DIV_MEAN) begin
            dreq.start = 1'b1;
            dreq.num   = NUM_W'(ws_abs);
            dreq.den   = DEN_W'(cnt_q);
            dreq.top   = KW'(Q_W - 1);
            dwait_d    = 1'b1;
          end else if (ws_q <= 0 || mom_sel <= 0) begin
            dsel_d = dsel_q + 2'd1;
          end else begin
            dreq.start = 1'b1;
            dreq.num   = NUM_W'(mom_sel) << 8;
            dreq.den   = DEN_W'(ws_q);
            dreq.top   = KW'(CENT_BITS);
            dwait_d    = 1'b1;
          end
        end else if (div_done) begin
          dwait_d = 1'b0;
          case (dsel_q)
            DIV_CCOL: begin
              res_d.centroid_col = (|div_q[Q_W-1:CENT_BITS]) ? '1 : div_q[CENT_BITS-1:0];
              dsel_d = DIV_CROW;
            end
            DIV_CROW: begin
              res_d.centroid_row = (|div_q[Q_W-1:CENT_BITS]) ? '1 : div_q[CENT_BITS-1:0];
              dsel_d = DIV_MEAN;
            end
            default: begin
              res_d.zone_mean = ws_q[WS_W-1] ? $signed(q_neg[SAMPLE_BITS-1:0])
                                             : $signed(div_q[SAMPLE_BITS-1:0]);
              state_d = ST_FIN;
            end
          endcase
        end
      end

      ST_FIN: begin
        if (!out_v_q || m_axis_tready) begin
          out_v_d = 1'b1;
          out_d   = res_q;
          state_d = ST_IDLE;
        end
      end

      // Turn the zone into excluded cells
      ST_RET: begin
        if (s1_v_q && rd_mark == MARK_ZONE) begin
          sreq.mk_we   = 1'b1;
          sreq.mk_addr = s1_i_q;
          sreq.mk_data = MARK_EXCL;
        end
        if (sweep_end) begin
          state_d = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase

    // Sweep start
    if (start_sweep) begin
      sw_i_d = '0;
      sw_x_d = '0;
      sw_y_d = '0;
      s1_v_d = 1'b0;
      s2_v_d = 1'b0;
      ws_d   = '0;
      cm_d   = '0;
      rm_d   = '0;
      cnt_d  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      w_q        <= DIM_W'(MAX_DIM);
      h_q        <= DIM_W'(MAX_DIM);
      thr_q      <= '0;
      sw_i_q     <= '0;
      sw_x_q     <= '0;
      sw_y_q     <= '0;
      s1_v_q     <= 1'b0;
      s1_i_q     <= '0;
      s1_x_q     <= '0;
      s1_y_q     <= '0;
      s2_v_q     <= 1'b0;
      mx_q       <= '0;
      my_q       <= '0;
      s2_s_q     <= '0;
      ws_q       <= '0;
      cm_q       <= '0;
      rm_q       <= '0;
      cnt_q      <= '0;
      best_q     <= '0;
      seed_ok_q  <= 1'b0;
      seed_idx_q <= '0;
      seed_x_q   <= '0;
      seed_y_q   <= '0;
      r_q        <= '0;
      t_q        <= '0;
      seg_q      <= SEG_TOP;
      sub_q      <= SUB_CELL;
      grew_q     <= 1'b0;
      cell_s_q   <= '0;
      cell_m_q   <= MARK_FREE;
      a_z_q      <= 1'b0;
      dsel_q     <= DIV_CCOL;
      dwait_q    <= 1'b0;
      out_v_q    <= 1'b0;
      res_q      <= '0;
      out_q      <= '0;
    end else begin
      state_q    <= state_d;
      w_q        <= w_d;
      h_q        <= h_d;
      thr_q      <= thr_d;
      sw_i_q     <= sw_i_d;
      sw_x_q     <= sw_x_d;
      sw_y_q     <= sw_y_d;
      s1_v_q     <= s1_v_d;
      s1_i_q     <= s1_i_d;
      s1_x_q     <= s1_x_d;
      s1_y_q     <= s1_y_d;
      s2_v_q     <= s2_v_d;
      mx_q       <= mx_d;
      my_q       <= my_d;
      s2_s_q     <= s2_s_d;
      ws_q       <= ws_d;
      cm_q       <= cm_d;
      rm_q       <= rm_d;
      cnt_q      <= cnt_d;
      best_q     <= best_d;
      seed_ok_q  <= seed_ok_d;
      seed_idx_q <= seed_idx_d;
      seed_x_q   <= seed_x_d;
      seed_y_q   <= seed_y_d;
      r_q        <= r_d;
      t_q        <= t_d;
      seg_q      <= seg_d;
      sub_q      <= sub_d;
      grew_q     <= grew_d;
      cell_s_q   <= cell_s_d;
      cell_m_q   <= cell_m_d;
      a_z_q      <= a_z_d;
      dsel_q     <= dsel_d;
      dwait_q    <= dwait_d;
      out_v_q    <= out_v_d;
      res_q      <= res_d;
      out_q      <= out_d;
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = {{(OUT_W-RES_W){1'b0}}, out_q};

  // Ring growth only ever marks cells inside the matrix
  a_grow_inside: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_GROW && sreq.mk_we) |-> cell_in)
    else $error("zone mark written outside the matrix");

  // The divider works only while the sequencer waits on it
  a_div_owned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_DIV) |-> !div_busy)
    else $error("divider busy outside the divide phase");

  // A found zone always holds at least its seed
  a_found_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && out_q.found) |-> (out_q.zone_count != '0))
    else $error("found result with empty zone");

  // A find result never carries a mark
  a_find_mark: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && out_q.found) |-> (out_q.cell_mark == MARK_FREE))
    else $error("find result carries a cell mark");

endmodule
